// File: design/led_group_power_limiter_defines.svh
// Assertion macros for the LED group power limiter.
`ifndef LED_GROUP_POWER_LIMITER_DEFINES_SVH
`define LED_GROUP_POWER_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition in the same cycle as its trigger.
`define LGPL_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");
// Check a condition in the cycle after its trigger.
`define LGPL_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define LGPL_ASSERT_SAME(label, trig, cond)
`define LGPL_ASSERT_NEXT(label, trig, cond)
`endif

`endif

// File: design/lgpl_pkg.sv
`timescale 1ns / 1ps
package lgpl_pkg;

  localparam int MAX_GROUPS  = 256;
  localparam int GROUP_SHIFT = 8;
  localparam int TOTAL_SHIFT = 8;
  localparam int POWER_BITS  = 24;

  localparam int LIMIT_W = 24;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 8;
  localparam int SCALE_W = 16;
  localparam int CNT_W   = 4;
  localparam int PROD_W  = WORD_W + SCALE_W;

  localparam logic [SCALE_W-1:0] GROUP_UNITY = SCALE_W'(1 << GROUP_SHIFT);
  localparam logic [SCALE_W-1:0] TOTAL_UNITY = SCALE_W'(1 << TOTAL_SHIFT);
  localparam logic [CNT_W-1:0]   GROUP_LAST_STEP = CNT_W'(GROUP_SHIFT - 1);
  localparam logic [CNT_W-1:0]   TOTAL_LAST_STEP = CNT_W'(TOTAL_SHIFT - 1);
  localparam logic [IDX_W-1:0]   LAST_GROUP_IDX  = IDX_W'(MAX_GROUPS - 1);

  // Configuration register indexes
  localparam logic REG_GROUP_CAP = 1'b0;
  localparam logic REG_FRAME_CAP = 1'b1;

  // Result kinds
  localparam logic KIND_GROUP = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_MULTIPLY,
    ST_EMIT
  } lgpl_state_t;

  typedef struct packed {
    logic load_item;
    logic start_div;
    logic set_unity;
    logic div_step;
    logic mul;
    logic emit;
  } lgpl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
    logic is_total;
    logic last;
  } lgpl_status_t;

endpackage

// File: design/lgpl_ctrl.sv
`timescale 1ns / 1ps
module lgpl_ctrl import lgpl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  lgpl_status_t status,
  output lgpl_cmd_t    cmd
);

  lgpl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.need_div) begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIVIDE;
        end else begin
          cmd.set_unity = 1'b1;
          state_next    = ST_MULTIPLY;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_MULTIPLY;
        end
      end
      ST_MULTIPLY: begin
        cmd.mul    = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register can take the result
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (!status.is_total && status.last) begin
            state_next = ST_CHECK;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/lgpl_datapath.sv
`timescale 1ns / 1ps
module lgpl_datapath import lgpl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic [LIMIT_W-1:0] group_sum,
  input  logic               last_group,
  input  lgpl_cmd_t          cmd,
  output lgpl_status_t       status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic [IDX_W-1:0]   group_index,
  output logic [WORD_W-1:0]  power_in,
  output logic [SCALE_W-1:0] scale_factor,
  output logic [WORD_W-1:0]  power_out,
  output logic               last_result
);

  logic [LIMIT_W-1:0] group_cap;
  logic [LIMIT_W-1:0] frame_cap;
  logic [WORD_W-1:0]  total_sum;
  logic [IDX_W-1:0]   group_counter;
  logic               is_total;
  logic               last;
  logic [LIMIT_W-1:0] power;
  logic [WORD_W-1:0]  rem;
  logic [SCALE_W-1:0] quot;
  logic [CNT_W-1:0]   step;
  logic [PROD_W-1:0]  prod;

  logic [WORD_W-1:0]  op;
  logic [LIMIT_W-1:0] limit_sel;
  logic [WORD_W:0]    rem_sh;
  logic [WORD_W:0]    rem_diff;
  logic               fits;
  logic [WORD_W-1:0]  scaled;
  logic [WORD_W:0]    sum_wide;
  logic [WORD_W-1:0]  sum_sat;

  // Operand and limit for the phase in progress
  assign op        = is_total ? total_sum : WORD_W'(power);
  assign limit_sel = is_total ? frame_cap : group_cap;

  // One restoring division step; the low dividend bits are zero
  assign rem_sh   = {rem, 1'b0};
  assign rem_diff = rem_sh - {1'b0, op};
  assign fits     = (rem_sh >= {1'b0, op});

  assign scaled   = is_total ? prod[TOTAL_SHIFT +: WORD_W] : prod[GROUP_SHIFT +: WORD_W];
  assign sum_wide = {1'b0, total_sum} + {1'b0, scaled};
  assign sum_sat  = sum_wide[WORD_W] ? '1 : sum_wide[WORD_W-1:0];

  assign status.need_div = (limit_sel != '0) && (op > WORD_W'(limit_sel));
  assign status.div_done = is_total ? (step == TOTAL_LAST_STEP) : (step == GROUP_LAST_STEP);
  assign status.out_free = !out_valid || out_ready;
  assign status.is_total = is_total;
  assign status.last     = last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      group_cap <= '0;
      frame_cap <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GROUP_CAP: group_cap <= cfg_wdata;
        REG_FRAME_CAP: frame_cap <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      power <= group_sum & LIMIT_W'((64'd1 << POWER_BITS) - 64'd1);
      last  <= last_group;
    end
  end

  // Divider and multiplier
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      rem  <= WORD_W'(limit_sel);
      quot <= '0;
      step <= '0;
    end else if (cmd.set_unity) begin
      quot <= is_total ? TOTAL_UNITY : GROUP_UNITY;
    end else if (cmd.div_step) begin
      rem  <= fits ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quot <= {quot[SCALE_W-2:0], fits};
      step <= step + 1'b1;
    end
    if (cmd.mul) begin
      prod <= op * quot;
    end
  end

  // Frame state: running sum, group counter and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      total_sum     <= '0;
      group_counter <= '0;
      is_total      <= 1'b0;
    end else if (cmd.emit) begin
      if (is_total) begin
        total_sum     <= '0;
        group_counter <= '0;
        is_total      <= 1'b0;
      end else begin
        total_sum <= sum_sat;
        if (last) begin
          is_total <= 1'b1;
        end else if (group_counter == LAST_GROUP_IDX) begin
          group_counter <= '0;
        end else begin
          group_counter <= group_counter + 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_kind  <= is_total ? KIND_TOTAL : KIND_GROUP;
      group_index  <= group_counter;
      power_in     <= op;
      scale_factor <= quot;
      power_out    <= scaled;
      last_result  <= is_total || !last;
    end
  end

endmodule

// File: design/led_group_power_limiter.sv
`timescale 1ns / 1ps
// An accepted request is captured and checked against its limit. Only when the limit is
// exceeded does the restoring divider run, one bit a cycle; the result is then multiplied.
// It is held until the output register is free. A last group adds a total result by the same steps.
// A new request is taken only after the previous one, and any total result, has been emitted.
// Reset (rst, synchronous): clears limits, running sum, group counter and output valid.
`include "led_group_power_limiter_defines.svh"
module led_group_power_limiter import lgpl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [LIMIT_W-1:0] group_sum,
  input  logic               last_group,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic [IDX_W-1:0]   group_index,
  output logic [WORD_W-1:0]  power_in,
  output logic [SCALE_W-1:0] scale_factor,
  output logic [WORD_W-1:0]  power_out,
  output logic               last_result
);

  lgpl_cmd_t    cmd;
  lgpl_status_t status;

  lgpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lgpl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .group_sum    (group_sum),
    .last_group   (last_group),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .group_index  (group_index),
    .power_in     (power_in),
    .scale_factor (scale_factor),
    .power_out    (power_out),
    .last_result  (last_result)
  );

  // One request in flight at a time
  `LGPL_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)
  // A total result always closes the request
  `LGPL_ASSERT_SAME(a_total_last, out_valid && result_kind, last_result)
  // Scaling never raises power
  `LGPL_ASSERT_SAME(a_no_gain, out_valid, power_out <= power_in)
  // Group multiplier never exceeds unity
  `LGPL_ASSERT_SAME(a_group_scale, out_valid && !result_kind, scale_factor <= GROUP_UNITY)

endmodule
